// ===== rtl/core/twsb_pkg.sv =====
// types and constants shared by the time window sample buffer modules
package twsb_pkg;

    localparam int STAMP_W  = 64;
    localparam int VALUE_W  = 64;
    localparam int WINDOW_W = 48;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH       = 3'd1,
        CELL_SHIFT_PUSH = 3'd2,
        CELL_SHIFT      = 3'd3,
        CELL_ROTATE     = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVICT = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

// ===== rtl/core/twsb_cell.sv =====
// one storage cell of the sample chain: holds one timestamped sample
module twsb_cell
    import twsb_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     nbr,
    input  entry_t     head,
    input  entry_t     load,
    output entry_t     q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_PUSH:
            begin
                if (ctrl.sel)
                begin
                    entry_next = load;
                end
            end
            CELL_SHIFT_PUSH:
            begin
                entry_next = ctrl.sel ? load : nbr;
            end
            CELL_SHIFT:
            begin
                entry_next = nbr;
            end
            CELL_ROTATE:
            begin
                // tail cell takes the head so the run comes back in order
                entry_next = ctrl.sel ? head : nbr;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== rtl/core/time_window_sample_buffer.sv =====
// Sliding time-window buffer. Each input word (now_time, sample_value) is appended to a chain
// of DEPTH cells kept oldest first; when the chain is full the oldest sample is pushed out and
// every output word of that batch carries tuser = 1. Samples older than window_ns relative to
// now_time are then evicted one per cycle from the head until the head sample is no longer older
// than that (the newest one is always kept), and every kept sample is sent oldest first with
// batch_time = now_time and tlast on the newest. Each item goes through ST_IDLE, where it is
// accepted, ST_EVICT, which evicts and ends with the final age test on the head cell, and
// ST_EMIT, which sends one kept sample (up to DEPTH) per cycle while the output is not stalled
// and the chain rotates past its head. Input is taken only between batches; the last output
// word may still wait in the output register when the next one is accepted.
module time_window_sample_buffer
    import twsb_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [WINDOW_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,   // now_time, sample_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // batch_time, kept_value
    output logic                  m_tlast,   // is_last
    output logic                  m_tuser    // dropped_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     emit_idx_reg, emit_idx_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic                 dropped_reg, dropped_next;
    logic [WINDOW_W-1:0]  window_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [127:0]         m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 m_tuser_reg, m_tuser_next;

    cell_op_t             op;
    logic [CNT_W-1:0]     sel_pos;
    entry_t               cell_q [DEPTH];
    entry_t               in_entry;
    logic                 full;
    logic                 slot_free;
    logic                 emit_last;
    logic [STAMP_W:0]     age;
    logic                 expired;

    assign in_entry.stamp = s_tdata[63:0];
    assign in_entry.value = s_tdata[127:64];

    assign full      = (count_reg == FULL_CNT);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit_last = (emit_idx_reg == count_reg - CNT_W'(1));

    // 65-bit age: no borrow means now is not older than the head sample
    assign age     = {1'b0, now_reg} - {1'b0, cell_q[0].stamp};
    assign expired = !age[STAMP_W] && (age[STAMP_W-1:0] > {{(STAMP_W-WINDOW_W){1'b0}}, window_reg});

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        now_next      = now_reg;
        dropped_next  = dropped_reg;
        op            = CELL_HOLD;
        sel_pos       = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next     = s_tdata[63:0];
                    dropped_next = full;
                    state_next   = ST_EVICT;
                    if (full)
                    begin
                        op      = CELL_SHIFT_PUSH;
                        sel_pos = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        op         = CELL_PUSH;
                        sel_pos    = count_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_EVICT:
            begin
                if (count_reg > CNT_W'(1) && expired)
                begin
                    op         = CELL_SHIFT;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    op            = CELL_ROTATE;
                    sel_pos       = count_reg - CNT_W'(1);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cell_q[0].value, now_reg};
                    m_tlast_next  = emit_last;
                    m_tuser_next  = dropped_reg;
                    emit_idx_next = emit_idx_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     nbr;

        assign ctrl.op  = op;
        assign ctrl.sel = (CNT_W'(i) == sel_pos);

        if (i == DEPTH - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i+1];
        end

        twsb_cell u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .nbr  (nbr),
            .head (cell_q[0]),
            .load (in_entry),
            .q    (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            emit_idx_reg <= '0;
            dropped_reg  <= 1'b0;
            window_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            emit_idx_reg <= emit_idx_next;
            dropped_reg  <= dropped_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("sample count above depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("emitting from an empty chain");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && full) |=> (count_reg == FULL_CNT && dropped_reg))
        else $error("push into full chain lost count or drop flag");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && emit_last) |=> (state_reg == ST_IDLE && m_tlast))
        else $error("last word did not close the batch");

endmodule

// ===== verif/time_window_sample_buffer_test.sv =====
// testbench for time_window_sample_buffer: sample stream with a window predictor and word scoreboard
module time_window_sample_buffer_test;
    import twsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 100;
    localparam int TARGET_ITEMS = 360;
    localparam int EXP_SLOTS   = 128;

    localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;

    typedef struct {
        logic [STAMP_W-1:0] batch_time;
        logic [VALUE_W-1:0] kept_value;
        logic               is_last;
        logic               dropped_full;
    } batch_word_t;

    // keeps its own copy of the window buffer and the words each sample must produce
    class window_scoreboard;
        logic [STAMP_W-1:0]  stamps [DEPTH];
        logic [VALUE_W-1:0]  samples [DEPTH];
        int unsigned         head;
        int unsigned         fill;
        logic [WINDOW_W-1:0] window;
        // ring of expected words, at most one batch plus one waiting word in flight
        batch_word_t         expected_words [EXP_SLOTS];
        int unsigned         exp_rd;
        int unsigned         exp_wr;
        int                  errors;

        function new();
            head   = 0;
            fill   = 0;
            window = '0;
            exp_rd = 0;
            exp_wr = 0;
            errors = 0;
        endfunction

        function void set_window(logic [WINDOW_W-1:0] w);
            window = w;
        endfunction

        function bit aged_out(logic [STAMP_W-1:0] stamp, logic [STAMP_W-1:0] now);
            return (now > stamp) && ((now - stamp) > {{(STAMP_W-WINDOW_W){1'b0}}, window});
        endfunction

        function void note_sample(logic [STAMP_W-1:0] now, logic [VALUE_W-1:0] value);
            logic        dropped;
            int unsigned k;
            batch_word_t w;
            dropped = 1'b0;
            // full: oldest entry goes regardless of its age
            if (fill == DEPTH)
            begin
                head    = (head + 1) % DEPTH;
                fill    = fill - 1;
                dropped = 1'b1;
            end
            stamps[(head + fill) % DEPTH]  = now;
            samples[(head + fill) % DEPTH] = value;
            fill = fill + 1;
            while (fill > 1 && aged_out(stamps[head], now))
            begin
                head = (head + 1) % DEPTH;
                fill = fill - 1;
            end
            for (k = 0; k < fill; k++)
            begin
                w.batch_time   = now;
                w.kept_value   = samples[(head + k) % DEPTH];
                w.is_last      = (k + 1 == fill);
                w.dropped_full = dropped;
                expected_words[exp_wr % EXP_SLOTS] = w;
                exp_wr++;
            end
        endfunction

        function void report(string field, logic [63:0] exp_val, logic [63:0] act_val);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $realtime, field, exp_val, act_val);
        endfunction

        function void check_word(logic [STAMP_W-1:0] batch_time, logic [VALUE_W-1:0] kept_value,
                                 logic is_last, logic dropped_full);
            batch_word_t w;
            if (exp_wr == exp_rd)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected output word, expected none, actual %h %h %b %b",
                             $realtime, batch_time, kept_value, is_last, dropped_full);
                return;
            end
            w = expected_words[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (batch_time !== w.batch_time)
                report("batch_time", w.batch_time, batch_time);
            if (kept_value !== w.kept_value)
                report("kept_value", w.kept_value, kept_value);
            if (is_last !== w.is_last)
                report("is_last", 64'(w.is_last), 64'(is_last));
            if (dropped_full !== w.dropped_full)
                report("dropped_full", 64'(w.dropped_full), 64'(dropped_full));
        endfunction

        function int pending();
            return int'(exp_wr - exp_rd);
        endfunction

        function void close();
            if (pending() != 0)
            begin
                errors++;
                $display("%0t: %0d output words still expected, expected none left, actual %0d",
                         $realtime, pending(), pending());
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [WINDOW_W-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [127:0]        s_tdata = '0;   // now_time, sample_value
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [127:0]        m_tdata;        // batch_time, kept_value
    logic                m_tlast;        // is_last
    logic                m_tuser;        // dropped_full

    window_scoreboard sb;
    bit               src_idle = 1'b1;
    bit               snk_idle = 1'b1;
    bit               hold_req = 1'b0;
    int               sent = 0;
    int               cycles = 0;
    logic [STAMP_W-1:0] stamp_now = '0;

    time_window_sample_buffer #(.DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls per word, plus one long hold-off on request
    initial
    begin
        int stall;
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = snk_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata[63:0], m_tdata[127:64], m_tlast, m_tuser);
    end

    task automatic send_sample(input logic [STAMP_W-1:0] now, input logic [VALUE_W-1:0] value);
        int gap;
        gap = src_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, now};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_sample(now, value);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_window(w);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly a rising time base; now and then a stray timestamp anywhere in the range
    task automatic run_stream(input int count, input int unsigned step_max);
        int i;
        logic [STAMP_W-1:0] now;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                now = rand64();
            else
            begin
                stamp_now = stamp_now + $urandom_range(0, step_max);
                now = stamp_now;
            end
            send_sample(now, rand64());
        end
    endtask

    initial
    begin
        logic [WINDOW_W-1:0] w;
        int unsigned         step_max;
        int                  phase;
        sb = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero window: equal stamps stay, any older stamp goes, late stamps stay
        write_window('0);
        send_sample(64'd0, 64'd0);
        send_sample(64'd0, '1);
        send_sample(64'd1, rand64());
        send_sample(64'd0, rand64());
        drain();

        // age exactly at the window is kept, one past it is evicted
        write_window(48'd100);
        send_sample(64'd1001, rand64());
        send_sample(64'd1101, rand64());
        send_sample(64'd1102, rand64());
        drain();

        write_window(WINDOW_MAX);
        send_sample(64'd1102 + {16'd0, WINDOW_MAX}, rand64());
        send_sample('1, '1);
        send_sample(64'd0, rand64());
        send_sample(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();

        phase = 0;
        while (sent < TARGET_ITEMS)
        begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    w = '0;
                    step_max = 3;
                end
                1:
                begin
                    w = 48'($urandom_range(0, 2000));
                    step_max = $urandom_range(1, 400);
                end
                2:
                begin
                    w = WINDOW_MAX;
                    step_max = 1000;
                end
                default:
                begin
                    w = {16'($urandom), $urandom};
                    step_max = 1000;
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                stamp_now = rand64();
            write_window(w);
            if (phase == 1)
            begin
                // receiver stops for a long stretch while words keep coming
                src_idle = 1'b0;
                hold_req = 1'b1;
            end
            run_stream($urandom_range(20, 45), step_max);
            drain();
            phase++;
        end

        drain();
        repeat (40) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== time_window_sample_buffer.f =====
rtl/core/twsb_pkg.sv
rtl/core/twsb_cell.sv
rtl/core/time_window_sample_buffer.sv
verif/time_window_sample_buffer_test.sv
